### hdl/pbd_pkg.sv
// Package for the pulse beat detector: codes, state types, constants and
// register layout shared by the detector's modules.
// Depends on nothing; compile it first.
package pbd_pkg;

    // Detector modes, in the order of the beat detector's life cycle.
    typedef enum logic [2:0] {
        MODE_INIT,
        MODE_WAITING,
        MODE_SLOPE,
        MODE_MAYBE,
        MODE_MASKING
    } mode_t;

    // Steps of the back-end sequencer.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DC,
        ST_AC,
        ST_LP1,
        ST_LP2,
        ST_LP3,
        ST_SCALE,
        ST_DET,
        ST_LOWER,
        ST_FALL0,
        ST_FALL,
        ST_DECAY,
        ST_PER,
        ST_RATE0,
        ST_RATE,
        ST_OUT
    } seq_state_t;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_DC_ALPHA       = 3'd0;
    localparam logic [2:0] REG_MIN_THRESHOLD  = 3'd1;
    localparam logic [2:0] REG_MAX_THRESHOLD  = 3'd2;
    localparam logic [2:0] REG_STEP_MARGIN    = 3'd3;
    localparam logic [2:0] REG_INIT_HOLDOFF   = 3'd4;
    localparam logic [2:0] REG_MASK_HOLDOFF   = 3'd5;
    localparam logic [2:0] REG_LOST_TIMEOUT   = 3'd6;
    localparam logic [2:0] REG_SAMPLE_PERIOD  = 3'd7;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Register values after reset.
    localparam logic [15:0] RST_DC_ALPHA      = 16'd62259;
    localparam logic [15:0] RST_MIN_THRESHOLD = 16'd20;
    localparam logic [15:0] RST_MAX_THRESHOLD = 16'd800;
    localparam logic [15:0] RST_STEP_MARGIN   = 16'd30;
    localparam logic [15:0] RST_INIT_HOLDOFF  = 16'd2000;
    localparam logic [15:0] RST_MASK_HOLDOFF  = 16'd200;
    localparam logic [15:0] RST_LOST_TIMEOUT  = 16'd2000;
    localparam logic [7:0]  RST_SAMPLE_PERIOD = 8'd43;

    typedef struct packed {
        logic [15:0] dc_alpha;
        logic [15:0] min_threshold;
        logic [15:0] max_threshold;
        logic [15:0] step_margin;
        logic [15:0] init_holdoff_ms;
        logic [15:0] masking_holdoff_ms;
        logic [15:0] lost_timeout_ms;
        logic [7:0]  sample_period_ms;
    } cfg_t;

    // Filter and detector constants (Q0.16 coefficients; SCALE_FACTOR is an integer).
    localparam logic signed [16:0] LP_GAIN      = 17'sd16072;
    localparam logic signed [16:0] LP_FEEDBACK  = 17'sd33392;
    localparam logic signed [16:0] DECAY_Q16    = 17'sd64881;
    localparam logic signed [12:0] SCALE_FACTOR = 13'sd4000;

    localparam int DC_W = 40;
    localparam logic [DC_W-1:0] DC_MAX = 40'h7F_FFFF_FFFF;

    localparam int FV_W   = 22;
    localparam int RATE_W = 10;
    localparam logic [RATE_W-1:0] RATE_MAX = 10'd1023;
    localparam logic [47:0] RATE_NUM = 48'd60000;

    // Shared divider sizes.
    localparam int DIV_NUM_W = 48;
    localparam int DIV_DEN_W = 32;

    localparam int Q_DEPTH = 4;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } div_rsp_t;

endpackage

### hdl/pbd_if.sv
// Handshake channels of the pulse beat detector: sample items in, result
// items out. Depends on pbd_pkg for the result field widths.
interface pbd_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] ir_sample;
    logic [31:0]            time_ms;

    modport source (output valid, output ir_sample, output time_ms, input ready);
    modport sink   (input valid, input ir_sample, input time_ms, output ready);
endinterface

interface pbd_out_if;
    import pbd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     beat;
    logic signed [FV_W-1:0]   filtered_value;
    logic [RATE_W-1:0]        rate_bpm;

    modport source (output valid, output beat, output filtered_value, output rate_bpm,
                    input ready);
    modport sink   (input valid, input beat, input filtered_value, input rate_bpm,
                    output ready);
endinterface

### hdl/pbd_queue.sv
// Front end of the detector: a short FIFO that takes sample items from the
// input channel and hands them to the back end. Depends on pbd_pkg, pbd_if.
module pbd_queue #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    pbd_in_if.sink                 sample_ch,
    output logic                   item_valid,
    input  logic                   item_pop,
    output logic [SAMPLE_BITS-1:0] item_sample,
    output logic [31:0]            item_time
);
    import pbd_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int W     = SAMPLE_BITS + 32;

    logic [W-1:0]     mem_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             push, pop;

    assign sample_ch.ready = (count_reg != (PTR_W+1)'(Q_DEPTH));
    assign item_valid      = (count_reg != '0);
    assign push            = sample_ch.valid && sample_ch.ready;
    assign pop             = item_pop && item_valid;
    assign {item_time, item_sample} = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Item storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= {sample_ch.time_ms, sample_ch.ir_sample};
        end
    end

endmodule

### hdl/pbd_divider.sv
// Shared unsigned divider of the detector, two quotient bits per cycle.
// Depends on pbd_pkg for the request and response structs.
module pbd_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  pbd_pkg::div_req_t req,
    output pbd_pkg::div_rsp_t rsp
);
    import pbd_pkg::*;

    localparam int ITER  = DIV_NUM_W / 2;
    localparam int CNT_W = $clog2(ITER);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W:0]   r1, r1s, r2, r2s;
    logic                 q1, q2;

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

    // Two restoring steps per cycle.
    always_comb
    begin
        r1  = {rem_reg, num_reg[DIV_NUM_W-1]};
        q1  = (r1 >= {1'b0, den_reg});
        r1s = q1 ? r1 - {1'b0, den_reg} : r1;
        r2  = {r1s[DIV_DEN_W-1:0], num_reg[DIV_NUM_W-2]};
        q2  = (r2 >= {1'b0, den_reg});
        r2s = q2 ? r2 - {1'b0, den_reg} : r2;

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = req.num;
            den_next  = req.den;
            quo_next  = '0;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            num_next = num_reg << 2;
            quo_next = {quo_reg[DIV_NUM_W-3:0], q1, q2};
            rem_next = r2s[DIV_DEN_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ITER - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

endmodule

### hdl/pbd_engine.sv
// Back end of the detector: a sequencer that runs the DC remover, the
// low-pass, the scaling and the beat detector for one item at a time, and
// holds the result register. Depends on pbd_pkg and pbd_if; the divider is reached through the div ports.
module pbd_engine #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pbd_pkg::cfg_t          cfg,
    input  logic                   item_valid,
    output logic                   item_pop,
    input  logic [SAMPLE_BITS-1:0] item_sample,
    input  logic [31:0]            item_time,
    output pbd_pkg::div_req_t      div_req,
    input  pbd_pkg::div_rsp_t      div_rsp,
    pbd_out_if.source              result_ch
);
    import pbd_pkg::*;

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;
    localparam logic signed [32:0] FV_MAX  = 33'sd2097151;
    localparam logic signed [32:0] FV_MIN  = -33'sd2097152;

    // Reciprocal of five, scaled by 2^29; exact for numerators below 2^27.
    localparam logic [26:0] PER_RECIP = 27'd107374183;
    localparam int          PER_SHIFT = 29;

    // Saturate to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX)
            r = 32'sh7FFF_FFFF;
        else if (v < S32_MIN)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Integer register value to fixed point, saturated.
    function automatic logic signed [31:0] to_q(input logic [15:0] v);
        logic [32:0] w;
        w = 33'(v) << FRAC_BITS;
        return (w > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(w[31:0]);
    endfunction

    // Detector state.
    seq_state_t         state_reg, state_next;
    mode_t              mode_reg, mode_next;
    logic [DC_W-1:0]    dc_reg, dc_next;
    logic signed [31:0] lp_curr_reg, lp_curr_next;
    logic signed [31:0] thr_reg, thr_next;
    logic signed [31:0] peak_reg, peak_next;
    logic [23:0]        period_reg, period_next;
    logic [31:0]        lbt_reg, lbt_next;
    logic               res_valid_reg, res_valid_next;

    // Per-item working registers.
    logic [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic [31:0]            time_reg, time_next;
    logic [55:0]            dcprod_reg, dcprod_next;
    logic signed [31:0]     ac_reg, ac_next;
    logic signed [49:0]     p1_reg, p1_next;
    logic signed [49:0]     p2_reg, p2_next;
    logic signed [31:0]     y_reg, y_next;
    logic signed [31:0]     s_reg, s_next;
    logic signed [FV_W-1:0] fv_reg, fv_next;
    logic [41:0]            fall_reg, fall_next;
    logic signed [48:0]     dec_reg, dec_next;
    logic [26:0]            per_num_reg, per_num_next;
    logic                   beat_reg, beat_next;
    logic [RATE_W-1:0]      rate_reg, rate_next;
    logic                   res_beat_reg, res_beat_next;
    logic signed [FV_W-1:0] res_fv_reg, res_fv_next;
    logic [RATE_W-1:0]      res_rate_reg, res_rate_next;

    // Datapath helpers.
    logic [DC_W-1:0]    x_val, dc_term, dc_new;
    logic [41:0]        dc_sum;
    logic signed [40:0] dc_diff;
    logic signed [32:0] neg_ac;
    logic signed [50:0] lp_sum;
    logic signed [31:0] curr_new;
    logic signed [44:0] s_prod;
    logic signed [32:0] y_ext, y_abs, y_trunc;
    logic [32:0]        y_shift;
    logic signed [31:0] cap, minq, stepq;
    logic signed [33:0] margin_sum;
    logic [31:0]        delta;
    logic [23:0]        d24;
    logic [10:0]        spx7;
    logic signed [49:0] fall_diff;
    logic signed [31:0] fall_thr, decay_thr;
    logic signed [50:0] decay_sum;
    logic [53:0]        per_prod;

    assign x_val   = DC_W'(sample_reg) << FRAC_BITS;
    assign dc_term = DC_W'((dcprod_reg + 56'd32768) >> 16);
    assign dc_sum  = 42'(x_val) + 42'(dc_term);
    assign dc_new  = (dc_sum > 42'(DC_MAX)) ? DC_MAX : dc_sum[DC_W-1:0];
    assign dc_diff = $signed({1'b0, dc_new}) - $signed({1'b0, dc_reg});
    assign neg_ac  = -(33'(ac_reg));
    assign lp_sum  = 51'(p1_reg) + 51'(p2_reg) + 51'sd32768;
    assign curr_new = sat32(64'(lp_sum >>> 16));
    assign s_prod  = y_reg * SCALE_FACTOR;

    // Truncate the low-pass output toward zero to an integer.
    assign y_ext   = 33'(y_reg);
    assign y_abs   = (y_ext < 0) ? -y_ext : y_ext;
    assign y_shift = $unsigned(y_abs) >> FRAC_BITS;
    assign y_trunc = (y_ext < 0) ? -$signed(y_shift) : $signed(y_shift);

    assign cap        = to_q(cfg.max_threshold);
    assign minq       = to_q(cfg.min_threshold);
    assign stepq      = to_q(cfg.step_margin);
    assign margin_sum = 34'(s_reg) + 34'(stepq);
    assign delta      = time_reg - lbt_reg;
    assign d24        = (delta > 32'h00FF_FFFF) ? 24'hFF_FFFF : delta[23:0];
    assign spx7       = 11'(cfg.sample_period_ms) * 11'd7;
    assign fall_diff  = 50'(thr_reg) - $signed({2'b00, div_rsp.quo});
    assign fall_thr   = sat32(64'(fall_diff));
    assign decay_sum  = 51'(dec_reg) + 51'sd32768;
    assign decay_thr  = sat32(64'(decay_sum >>> 16));
    assign per_prod   = 54'(per_num_reg) * 54'(PER_RECIP);

    assign result_ch.valid          = res_valid_reg;
    assign result_ch.beat           = res_beat_reg;
    assign result_ch.filtered_value = res_fv_reg;
    assign result_ch.rate_bpm       = res_rate_reg;

    // Sequencer: next state, datapath steps and divider requests.
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        dc_next        = dc_reg;
        lp_curr_next   = lp_curr_reg;
        thr_next       = thr_reg;
        peak_next      = peak_reg;
        period_next    = period_reg;
        lbt_next       = lbt_reg;
        res_valid_next = res_valid_reg && !result_ch.ready;
        sample_next    = sample_reg;
        time_next      = time_reg;
        dcprod_next    = dcprod_reg;
        ac_next        = ac_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        y_next         = y_reg;
        s_next         = s_reg;
        fv_next        = fv_reg;
        fall_next      = fall_reg;
        dec_next       = dec_reg;
        per_num_next   = per_num_reg;
        beat_next      = beat_reg;
        rate_next      = rate_reg;
        res_beat_next  = res_beat_reg;
        res_fv_next    = res_fv_reg;
        res_rate_next  = res_rate_reg;
        item_pop       = 1'b0;
        div_req.start  = 1'b0;
        div_req.num    = '0;
        div_req.den    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_pop    = 1'b1;
                    sample_next = item_sample;
                    time_next   = item_time;
                    beat_next   = 1'b0;
                    state_next  = ST_DC;
                end
            end
            ST_DC:
            begin
                dcprod_next = dc_reg * cfg.dc_alpha;
                state_next  = ST_AC;
            end
            ST_AC:
            begin
                dc_next    = dc_new;
                ac_next    = sat32(64'(dc_diff));
                state_next = ST_LP1;
            end
            ST_LP1:
            begin
                p1_next    = neg_ac * LP_GAIN;
                state_next = ST_LP2;
            end
            ST_LP2:
            begin
                p2_next    = lp_curr_reg * LP_FEEDBACK;
                state_next = ST_LP3;
            end
            ST_LP3:
            begin
                // The old current value becomes the previous one.
                lp_curr_next = curr_new;
                y_next       = sat32(64'(lp_curr_reg) + 64'(curr_new));
                state_next   = ST_SCALE;
            end
            ST_SCALE:
            begin
                s_next = sat32(64'(s_prod));
                if (y_trunc > FV_MAX)
                    fv_next = FV_MAX[FV_W-1:0];
                else if (y_trunc < FV_MIN)
                    fv_next = FV_MIN[FV_W-1:0];
                else
                    fv_next = y_trunc[FV_W-1:0];
                state_next = ST_DET;
            end
            ST_DET:
            begin
                state_next = ST_RATE0;
                case (mode_reg)
                    MODE_WAITING:
                    begin
                        if (s_reg > thr_reg)
                        begin
                            thr_next  = (s_reg < cap) ? s_reg : cap;
                            mode_next = MODE_SLOPE;
                        end
                        if (delta > 32'(cfg.lost_timeout_ms))
                        begin
                            period_next = '0;
                            peak_next   = '0;
                        end
                        state_next = ST_LOWER;
                    end
                    MODE_SLOPE:
                    begin
                        if (s_reg < thr_reg)
                            mode_next = MODE_MAYBE;
                        else
                            thr_next = (s_reg < cap) ? s_reg : cap;
                    end
                    MODE_MAYBE:
                    begin
                        if (margin_sum < 34'(thr_reg))
                        begin
                            beat_next = 1'b1;
                            peak_next = s_reg;
                            mode_next = MODE_MASKING;
                            lbt_next  = time_reg;
                            if (delta != '0)
                            begin
                                // Period average numerator: 3*delta + 2*period + 2.
                                per_num_next = 27'(d24) * 27'd3 + 27'(period_reg) * 27'd2
                                               + 27'd2;
                                state_next   = ST_PER;
                            end
                        end
                        else
                        begin
                            mode_next = MODE_SLOPE;
                        end
                    end
                    MODE_MASKING:
                    begin
                        if (delta > 32'(cfg.masking_holdoff_ms))
                            mode_next = MODE_WAITING;
                        state_next = ST_LOWER;
                    end
                    default:
                    begin
                        mode_next = (time_reg > 32'(cfg.init_holdoff_ms)) ? MODE_WAITING
                                                                           : MODE_INIT;
                    end
                endcase
            end
            ST_LOWER:
            begin
                // Linear falloff scaled by the last peak, or plain decay.
                if (peak_reg > 0 && period_reg != '0)
                begin
                    fall_next  = peak_reg[30:0] * spx7;
                    state_next = ST_FALL0;
                end
                else
                begin
                    dec_next   = thr_reg * DECAY_Q16;
                    state_next = ST_DECAY;
                end
            end
            ST_FALL0:
            begin
                div_req.start = 1'b1;
                div_req.num   = 48'(fall_reg) + 48'(period_reg) * 48'd5;
                div_req.den   = 32'(period_reg) * 32'd10;
                state_next    = ST_FALL;
            end
            ST_FALL:
            begin
                if (div_rsp.done)
                begin
                    thr_next   = (fall_thr < minq) ? minq : fall_thr;
                    state_next = ST_RATE0;
                end
            end
            ST_DECAY:
            begin
                thr_next   = (decay_thr < minq) ? minq : decay_thr;
                state_next = ST_RATE0;
            end
            ST_PER:
            begin
                // Divide the period numerator by five with the reciprocal.
                period_next = per_prod[PER_SHIFT+23:PER_SHIFT];
                state_next  = ST_RATE0;
            end
            ST_RATE0:
            begin
                if (period_reg != '0)
                begin
                    div_req.start = 1'b1;
                    div_req.num   = RATE_NUM;
                    div_req.den   = 32'(period_reg);
                    state_next    = ST_RATE;
                end
                else
                begin
                    rate_next  = '0;
                    state_next = ST_OUT;
                end
            end
            ST_RATE:
            begin
                if (div_rsp.done)
                begin
                    rate_next  = (div_rsp.quo > 48'(RATE_MAX)) ? RATE_MAX
                                                               : div_rsp.quo[RATE_W-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // Load the result register once it is free.
                if (!res_valid_reg || result_ch.ready)
                begin
                    res_valid_next = 1'b1;
                    res_beat_next  = beat_reg;
                    res_fv_next    = fv_reg;
                    res_rate_next  = rate_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_INIT;
            dc_reg        <= '0;
            lp_curr_reg   <= '0;
            thr_reg       <= to_q(RST_MIN_THRESHOLD);
            peak_reg      <= '0;
            period_reg    <= '0;
            lbt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            dc_reg        <= dc_next;
            lp_curr_reg   <= lp_curr_next;
            thr_reg       <= thr_next;
            peak_reg      <= peak_next;
            period_reg    <= period_next;
            lbt_reg       <= lbt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        time_reg     <= time_next;
        dcprod_reg   <= dcprod_next;
        ac_reg       <= ac_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        y_reg        <= y_next;
        s_reg        <= s_next;
        fv_reg       <= fv_next;
        fall_reg     <= fall_next;
        dec_reg      <= dec_next;
        per_num_reg  <= per_num_next;
        beat_reg     <= beat_next;
        rate_reg     <= rate_next;
        res_beat_reg <= res_beat_next;
        res_fv_reg   <= res_fv_next;
        res_rate_reg <= res_rate_next;
    end

endmodule

### hdl/pulse_beat_detector_core.sv
// Top level of the pulse beat detector: configuration registers, the input
// queue, the processing sequencer and the shared divider.
// Depends on pbd_pkg, pbd_if, pbd_queue, pbd_divider and pbd_engine.
//
// Each sample item yields one result item (beat flag, filtered value, rate
// in bpm). Items are processed one at a time by a sequencer: filtering,
// detection and output, with further steps for a plain threshold decay,
// for the beat-period average (a divide by five done as a reciprocal
// multiply), and for each pass through a shared divider that retires two
// quotient bits per cycle: the threshold falloff (plus a setup state) and
// the bpm rate. A four-entry input queue and the result register let both
// channels stall independently. There is no clearing pass after reset.
// Registers must be written over the APB port only while no item is in
// flight; the block itself does not enforce this.
module pulse_beat_detector_core #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    pbd_in_if.sink                         sample_ch,
    pbd_out_if.source                      result_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pbd_pkg::ADDR_W-1:0]     paddr,
    input  logic [pbd_pkg::DATA_W-1:0]     pwdata,
    output logic [pbd_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);
    import pbd_pkg::*;

    cfg_t                   cfg_reg, cfg_next;
    logic                   item_valid, item_pop;
    logic [SAMPLE_BITS-1:0] item_sample;
    logic [31:0]            item_time;
    div_req_t               div_req;
    div_rsp_t               div_rsp;
    logic                   cfg_write;
    logic [2:0]             reg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = paddr[ADDR_W-1:2];

    // Register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (reg_index)
                REG_DC_ALPHA:      cfg_next.dc_alpha           = pwdata[15:0];
                REG_MIN_THRESHOLD: cfg_next.min_threshold      = pwdata[15:0];
                REG_MAX_THRESHOLD: cfg_next.max_threshold      = pwdata[15:0];
                REG_STEP_MARGIN:   cfg_next.step_margin        = pwdata[15:0];
                REG_INIT_HOLDOFF:  cfg_next.init_holdoff_ms    = pwdata[15:0];
                REG_MASK_HOLDOFF:  cfg_next.masking_holdoff_ms = pwdata[15:0];
                REG_LOST_TIMEOUT:  cfg_next.lost_timeout_ms    = pwdata[15:0];
                REG_SAMPLE_PERIOD: cfg_next.sample_period_ms   = pwdata[7:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (reg_index)
            REG_DC_ALPHA:      prdata = 32'(cfg_reg.dc_alpha);
            REG_MIN_THRESHOLD: prdata = 32'(cfg_reg.min_threshold);
            REG_MAX_THRESHOLD: prdata = 32'(cfg_reg.max_threshold);
            REG_STEP_MARGIN:   prdata = 32'(cfg_reg.step_margin);
            REG_INIT_HOLDOFF:  prdata = 32'(cfg_reg.init_holdoff_ms);
            REG_MASK_HOLDOFF:  prdata = 32'(cfg_reg.masking_holdoff_ms);
            REG_LOST_TIMEOUT:  prdata = 32'(cfg_reg.lost_timeout_ms);
            REG_SAMPLE_PERIOD: prdata = 32'(cfg_reg.sample_period_ms);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dc_alpha           <= RST_DC_ALPHA;
            cfg_reg.min_threshold      <= RST_MIN_THRESHOLD;
            cfg_reg.max_threshold      <= RST_MAX_THRESHOLD;
            cfg_reg.step_margin        <= RST_STEP_MARGIN;
            cfg_reg.init_holdoff_ms    <= RST_INIT_HOLDOFF;
            cfg_reg.masking_holdoff_ms <= RST_MASK_HOLDOFF;
            cfg_reg.lost_timeout_ms    <= RST_LOST_TIMEOUT;
            cfg_reg.sample_period_ms   <= RST_SAMPLE_PERIOD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: input queue.
    pbd_queue #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_ch   (sample_ch),
        .item_valid  (item_valid),
        .item_pop    (item_pop),
        .item_sample (item_sample),
        .item_time   (item_time)
    );

    // Shared divider.
    pbd_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Back end: filters and beat detector.
    pbd_engine #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .item_valid  (item_valid),
        .item_pop    (item_pop),
        .item_sample (item_sample),
        .item_time   (item_time),
        .div_req     (div_req),
        .div_rsp     (div_rsp),
        .result_ch   (result_ch)
    );

endmodule
